[rtl/step_dir_axis_controller_macros.svh]
// ----------------------------------------------------------------------------
// Step/direction controller assertion macros
// Shorthand for the clocked, reset-qualified properties of the checker.
// ----------------------------------------------------------------------------
`ifndef STEP_DIR_AXIS_CONTROLLER_MACROS_SVH
`define STEP_DIR_AXIS_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDAC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sdac_pkg.sv]
// ----------------------------------------------------------------------------
// sdac_pkg
// Types and constants shared by the step/direction axis controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sdac_pkg;

   // Transaction widths on the stream ports
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 8;
   localparam int RSP_TDATA_W = 80;
   localparam int FIELD_POS_W = 32;
   localparam int AXIS_FIELD_W = 2;

   typedef enum logic [3:0] {
      MODE_TICK       = 4'd0,
      MODE_ENABLE_ON  = 4'd1,
      MODE_ENABLE_OFF = 4'd2,
      MODE_HOME       = 4'd3,
      MODE_STOP       = 4'd4,
      MODE_JOG_PLUS   = 4'd5,
      MODE_JOG_MINUS  = 4'd6,
      MODE_MOVE       = 4'd7,
      MODE_GOTO       = 4'd8
   } sdac_mode_type;

   localparam logic signed [1:0] VEL_PLUS  = 2'sb01;
   localparam logic signed [1:0] VEL_MINUS = 2'sb11;
   localparam logic signed [1:0] VEL_IDLE  = 2'sb00;

   // Command seen by one axis unit
   typedef struct packed {
      logic          tick;
      logic          selected;
      sdac_mode_type mode;
   } sdac_axis_cmd_type;

   // Flags of one axis after the transaction has been applied
   typedef struct packed {
      logic              stepped;
      logic              arrived;
      logic              direction;
      logic              moving;
      logic              enabled;
      logic              homed;
      logic signed [1:0] velocity;
      logic              rejected;
   } sdac_axis_flags_type;

   // Result word, last field in the lowest bits
   typedef struct packed {
      logic [2:0]                     pad;
      logic signed [1:0]              axis_velocity;
      logic                           axis_homed;
      logic                           axis_enabled;
      logic                           axis_moving;
      logic signed [FIELD_POS_W-1:0]  axis_target;
      logic signed [FIELD_POS_W-1:0]  axis_position;
      logic [AXIS_FIELD_W-1:0]        arrived;
      logic                           driver_enable_n;
      logic [AXIS_FIELD_W-1:0]        step_directions;
      logic [AXIS_FIELD_W-1:0]        step_pulses;
      logic                           status;
   } sdac_result_type;

endpackage

`default_nettype wire

[rtl/sdac_axis.sv]
// ----------------------------------------------------------------------------
// sdac_axis
// State and next-state logic of one axis: position, target and motion flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sdac_axis #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire sdac_pkg::sdac_axis_cmd_type     cmd,
   input  wire logic [sdac_pkg::REQ_TDATA_W-1:0] amount,
   output logic [POSITION_BITS-1:0]             position_next,
   output logic [POSITION_BITS-1:0]             target_next,
   output sdac_pkg::sdac_axis_flags_type        flags_next
);

   localparam logic [POSITION_BITS-1:0] POS_TOP    = {1'b0, {(POSITION_BITS-1){1'b1}}};
   localparam logic [POSITION_BITS-1:0] POS_BOTTOM = {1'b1, {(POSITION_BITS-1){1'b0}}};

   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [POSITION_BITS-1:0] target_ff, target_in;
   logic signed [1:0]        velocity_ff, velocity_in;
   logic                     moving_ff, moving_in;
   logic                     enabled_ff, enabled_in;
   logic                     homed_ff, homed_in;
   logic                     direction_ff, direction_in;

   logic [POSITION_BITS-1:0] step_sum;
   logic [POSITION_BITS-1:0] amount_cut;
   logic                     stepped;
   logic                     arrived;
   logic                     rejected;

   always_comb begin
      position_in  = position_ff;
      target_in    = target_ff;
      velocity_in  = velocity_ff;
      moving_in    = moving_ff;
      enabled_in   = enabled_ff;
      homed_in     = homed_ff;
      direction_in = direction_ff;
      stepped      = 1'b0;
      arrived      = 1'b0;
      rejected     = 1'b0;
      step_sum     = position_ff + POSITION_BITS'(velocity_ff);
      amount_cut   = amount[POSITION_BITS-1:0];

      if (cmd.tick) begin
         if (moving_ff && enabled_ff) begin
            if (position_ff == target_ff) begin
               moving_in   = 1'b0;
               velocity_in = sdac_pkg::VEL_IDLE;
               arrived     = 1'b1;
            end else begin
               position_in  = step_sum;
               direction_in = ~velocity_ff[1];
               stepped      = 1'b1;
               // Jog end points are only caught on the following tick.
               if (target_ff != POS_TOP && target_ff != POS_BOTTOM &&
                   step_sum == target_ff) begin
                  moving_in   = 1'b0;
                  velocity_in = sdac_pkg::VEL_IDLE;
                  arrived     = 1'b1;
               end
            end
         end
      end else if (cmd.selected) begin
         if ((cmd.mode inside {[sdac_pkg::MODE_JOG_PLUS:sdac_pkg::MODE_GOTO]}) &&
             !enabled_ff) begin
            rejected = 1'b1;
         end else begin
            case (cmd.mode)
               sdac_pkg::MODE_ENABLE_ON: begin
                  enabled_in = 1'b1;
               end
               sdac_pkg::MODE_ENABLE_OFF: begin
                  enabled_in  = 1'b0;
                  moving_in   = 1'b0;
                  velocity_in = sdac_pkg::VEL_IDLE;
                  target_in   = position_ff;
               end
               sdac_pkg::MODE_HOME: begin
                  position_in = '0;
                  target_in   = '0;
                  moving_in   = 1'b0;
                  velocity_in = sdac_pkg::VEL_IDLE;
                  homed_in    = 1'b1;
               end
               sdac_pkg::MODE_STOP: begin
                  target_in   = position_ff;
                  moving_in   = 1'b0;
                  velocity_in = sdac_pkg::VEL_IDLE;
               end
               sdac_pkg::MODE_JOG_PLUS: begin
                  velocity_in = sdac_pkg::VEL_PLUS;
                  moving_in   = 1'b1;
                  target_in   = POS_TOP;
               end
               sdac_pkg::MODE_JOG_MINUS: begin
                  velocity_in = sdac_pkg::VEL_MINUS;
                  moving_in   = 1'b1;
                  target_in   = POS_BOTTOM;
               end
               sdac_pkg::MODE_MOVE: begin
                  target_in = position_ff + amount_cut;
                  // A zero step count is judged on the full 32-bit amount.
                  if (amount == '0) begin
                     moving_in   = 1'b0;
                     velocity_in = sdac_pkg::VEL_IDLE;
                  end else begin
                     velocity_in = amount[sdac_pkg::REQ_TDATA_W-1] ?
                                   sdac_pkg::VEL_MINUS : sdac_pkg::VEL_PLUS;
                     moving_in   = 1'b1;
                  end
               end
               sdac_pkg::MODE_GOTO: begin
                  target_in = amount_cut;
                  if (amount_cut == position_ff) begin
                     moving_in   = 1'b0;
                     velocity_in = sdac_pkg::VEL_IDLE;
                  end else begin
                     velocity_in = ($signed(amount_cut) > $signed(position_ff)) ?
                                   sdac_pkg::VEL_PLUS : sdac_pkg::VEL_MINUS;
                     moving_in   = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         target_ff    <= '0;
         velocity_ff  <= sdac_pkg::VEL_IDLE;
         moving_ff    <= 1'b0;
         enabled_ff   <= 1'b0;
         homed_ff     <= 1'b0;
         direction_ff <= 1'b0;
      end else if (advance) begin
         position_ff  <= position_in;
         target_ff    <= target_in;
         velocity_ff  <= velocity_in;
         moving_ff    <= moving_in;
         enabled_ff   <= enabled_in;
         homed_ff     <= homed_in;
         direction_ff <= direction_in;
      end
   end

   always_comb begin
      position_next        = position_in;
      target_next          = target_in;
      flags_next.stepped   = stepped;
      flags_next.arrived   = arrived;
      flags_next.direction = direction_in;
      flags_next.moving    = moving_in;
      flags_next.enabled   = enabled_in;
      flags_next.homed     = homed_in;
      flags_next.velocity  = velocity_in;
      flags_next.rejected  = rejected;
   end

endmodule

`default_nettype wire

[rtl/step_dir_axis_controller.sv]
// ----------------------------------------------------------------------------
// step_dir_axis_controller
// Multi-axis step/direction motion controller with stream ports.
// ----------------------------------------------------------------------------
// Usage
// Each request transaction carries one tick or one command for a single axis.
// req_tuser holds the mode and the addressed axis, req_tdata the signed
// amount used by move (relative) and goto (absolute). Every request yields
// exactly one response transaction on the rsp_ channel with the status, the
// step pulses and directions of this tick, the driver enable and the state
// of the addressed axis after the request has been applied.
// A request taken into the input stage is applied and registered as its
// response, and rsp_tvalid is high from then on. Throughput is one
// transaction per cycle while rsp_tready is high, set by the single input
// stage feeding the per-axis adders and the response register.
// Reset (synchronous, active high) clears all axes to position zero, idle,
// disabled and not homed, with the direction outputs low, and empties both
// stages. When the receiver holds rsp_tready low the response stays put,
// one further request is absorbed in the input stage, and req_tready then
// falls until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module step_dir_axis_controller #(
   parameter int AXIS_COUNT    = 2,
   parameter int POSITION_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // amount [31:0]
   input  wire logic [sdac_pkg::REQ_TDATA_W-1:0] req_tdata,
   // mode [3:0], axis_index [4], zero [7:5]
   input  wire logic [sdac_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // status [0], step_pulses [2:1], step_directions [4:3],
   // driver_enable_n [5], arrived [7:6], axis_position [39:8],
   // axis_target [71:40], axis_moving [72], axis_enabled [73],
   // axis_homed [74], axis_velocity [76:75], zero [79:77]
   output logic [sdac_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   // Input stage
   logic                                  s1_valid_ff, s1_valid_in;
   sdac_pkg::sdac_mode_type               s1_mode_ff;
   logic                                  s1_axis_ff;
   logic [sdac_pkg::REQ_TDATA_W-1:0]      s1_amount_ff;

   // Response stage
   logic                                  out_valid_ff, out_valid_in;
   sdac_pkg::sdac_result_type             result_ff, result_in;

   logic                                  req_fire;
   logic                                  advance;
   logic                                  index_ok;

   sdac_pkg::sdac_axis_cmd_type           axis_cmd   [AXIS_COUNT];
   sdac_pkg::sdac_axis_flags_type         axis_flags [AXIS_COUNT];
   logic [POSITION_BITS-1:0]              axis_pos   [AXIS_COUNT];
   logic [POSITION_BITS-1:0]              axis_tgt   [AXIS_COUNT];

   logic [AXIS_COUNT-1:0]                 pulse_vec;
   logic [AXIS_COUNT-1:0]                 dir_vec;
   logic [AXIS_COUNT-1:0]                 arrive_vec;
   logic [AXIS_COUNT-1:0]                 enable_vec;
   logic [AXIS_COUNT+1:0]                 pulse_ext;
   logic [AXIS_COUNT+1:0]                 dir_ext;
   logic [AXIS_COUNT+1:0]                 arrive_ext;

   // The input stage moves on whenever the response register is free or
   // being emptied in this cycle.
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign index_ok   = int'(s1_axis_ff) < AXIS_COUNT;

   assign s1_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_axis
      always_comb begin
         axis_cmd[a].tick     = (s1_mode_ff == sdac_pkg::MODE_TICK);
         axis_cmd[a].selected = (int'(s1_axis_ff) == a);
         axis_cmd[a].mode     = s1_mode_ff;
      end

      sdac_axis #(
         .POSITION_BITS (POSITION_BITS)
      ) u_axis (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .cmd           (axis_cmd[a]),
         .amount        (s1_amount_ff),
         .position_next (axis_pos[a]),
         .target_next   (axis_tgt[a]),
         .flags_next    (axis_flags[a])
      );

      assign pulse_vec[a]  = axis_flags[a].stepped;
      assign dir_vec[a]    = axis_flags[a].direction;
      assign arrive_vec[a] = axis_flags[a].arrived;
      assign enable_vec[a] = axis_flags[a].enabled;
   end

   // Pad the per-axis vectors so that the two-bit fields are always defined.
   assign pulse_ext  = {2'b00, pulse_vec};
   assign dir_ext    = {2'b00, dir_vec};
   assign arrive_ext = {2'b00, arrive_vec};

   always_comb begin
      result_in                 = '0;
      result_in.step_pulses     = pulse_ext[sdac_pkg::AXIS_FIELD_W-1:0];
      result_in.step_directions = dir_ext[sdac_pkg::AXIS_FIELD_W-1:0];
      result_in.arrived         = arrive_ext[sdac_pkg::AXIS_FIELD_W-1:0];
      result_in.driver_enable_n = ~(|enable_vec);
      // An out-of-range axis index leaves all per-axis fields at zero.
      for (int a = 0; a < AXIS_COUNT; a++) begin
         if (index_ok && int'(s1_axis_ff) == a) begin
            result_in.status        = axis_flags[a].rejected;
            result_in.axis_position = sdac_pkg::FIELD_POS_W'($signed(axis_pos[a]));
            result_in.axis_target   = sdac_pkg::FIELD_POS_W'($signed(axis_tgt[a]));
            result_in.axis_moving   = axis_flags[a].moving;
            result_in.axis_enabled  = axis_flags[a].enabled;
            result_in.axis_homed    = axis_flags[a].homed;
            result_in.axis_velocity = axis_flags[a].velocity;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff   <= sdac_pkg::sdac_mode_type'(req_tuser[3:0]);
         s1_axis_ff   <= req_tuser[4];
         s1_amount_ff <= req_tdata;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = result_ff;

endmodule

`default_nettype wire

[rtl/sdac_checker.sv]
// ----------------------------------------------------------------------------
// sdac_checker
// Port-level checks on the step/direction controller's response stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "step_dir_axis_controller_macros.svh"

module sdac_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [sdac_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   sdac_pkg::sdac_result_type rsp;

   assign rsp = rsp_tdata;

   // A stalled response must hold its contents.
   `SDAC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // A rejected command neither steps nor arrives, and its axis is disabled.
   `SDAC_ASSERT_NOW(a_reject_quiet, rsp_tvalid && rsp.status, rsp.step_pulses == '0 && rsp.arrived == '0 && !rsp.axis_enabled, "rejected command shows motion")

   // An enabled axis always drives the shared enable low.
   `SDAC_ASSERT_NOW(a_enable_drive, rsp_tvalid && rsp.axis_enabled, !rsp.driver_enable_n, "driver enable high with an axis enabled")

   // Velocity is non-zero exactly when the axis is moving.
   `SDAC_ASSERT_NOW(a_vel_moving, rsp_tvalid, rsp.axis_moving == (rsp.axis_velocity != 2'sb00), "velocity disagrees with moving flag")

   // With no response waiting the block always takes a request.
   `SDAC_ASSERT_NOW(a_ready_when_empty, !rsp_tvalid, req_tready, "request refused with the response register empty")

endmodule

bind step_dir_axis_controller sdac_checker u_sdac_checker (.*);

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-axis step/direction controller. A shadow
// model of both axes predicts the response to every accepted request, and
// each response taken from the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int          AXES          = 2;
   localparam logic [31:0] TOP_POSITION  = 32'h7FFF_FFFF;
   localparam logic [31:0] BOTTOM_POSITION = 32'h8000_0000;
   localparam int          RANDOM_PER_PHASE = 435;
   localparam int          DRAIN_LIMIT   = 10000;
   localparam int          SETTLE_CYCLES = 8;

   // Shadow of both axes plus the queue of responses still to come. The
   // prediction is made when a request transaction is accepted; the check is
   // made when a response transaction is accepted.
   class motion_scoreboard;
      logic [31:0]               position [AXES];
      logic [31:0]               target [AXES];
      logic signed [1:0]         velocity [AXES];
      bit                        moving [AXES];
      bit                        enabled [AXES];
      bit                        homed [AXES];
      bit                        direction [AXES];
      sdac_pkg::sdac_result_type predicted_responses [$];
      int                        failures;
      int                        reported;

      function new();
         for (int a = 0; a < AXES; a++) begin
            position[a]  = '0;
            target[a]    = '0;
            velocity[a]  = sdac_pkg::VEL_IDLE;
            moving[a]    = 1'b0;
            enabled[a]   = 1'b0;
            homed[a]     = 1'b0;
            direction[a] = 1'b0;
         end
         failures = 0;
         reported = 0;
      endfunction

      function void halt_axis(int a);
         moving[a]   = 1'b0;
         velocity[a] = sdac_pkg::VEL_IDLE;
      endfunction

      function void note_request(sdac_pkg::sdac_mode_type mode, bit axis,
                                 logic [31:0] amount);
         sdac_pkg::sdac_result_type r;
         logic [1:0]                pulses;
         logic [1:0]                arrivals;
         bit                        rejected;
         bit                        needs_enable;
         pulses   = '0;
         arrivals = '0;
         rejected = 1'b0;
         needs_enable = (mode == sdac_pkg::MODE_JOG_PLUS) ||
                        (mode == sdac_pkg::MODE_JOG_MINUS) ||
                        (mode == sdac_pkg::MODE_MOVE) || (mode == sdac_pkg::MODE_GOTO);
         if (mode == sdac_pkg::MODE_TICK) begin
            for (int a = 0; a < AXES; a++) begin
               if (moving[a] && enabled[a]) begin
                  if (position[a] == target[a]) begin
                     // Already at the target: stop without a step.
                     halt_axis(a);
                     arrivals[a] = 1'b1;
                  end else begin
                     position[a]  = position[a] + {{30{velocity[a][1]}}, velocity[a]};
                     direction[a] = !velocity[a][1];
                     pulses[a]    = 1'b1;
                     // A target at either end of the range is only seen on
                     // the following tick.
                     if (target[a] != TOP_POSITION && target[a] != BOTTOM_POSITION &&
                         position[a] == target[a]) begin
                        halt_axis(axis_of(a));
                        arrivals[a] = 1'b1;
                     end
                  end
               end
            end
         end else if (needs_enable && !enabled[axis]) begin
            rejected = 1'b1;
         end else begin
            case (mode)
               sdac_pkg::MODE_ENABLE_ON: begin
                  enabled[axis] = 1'b1;
               end
               sdac_pkg::MODE_ENABLE_OFF: begin
                  enabled[axis] = 1'b0;
                  halt_axis(axis);
                  target[axis] = position[axis];
               end
               sdac_pkg::MODE_HOME: begin
                  position[axis] = '0;
                  target[axis]   = '0;
                  halt_axis(axis);
                  homed[axis] = 1'b1;
               end
               sdac_pkg::MODE_STOP: begin
                  target[axis] = position[axis];
                  halt_axis(axis);
               end
               sdac_pkg::MODE_JOG_PLUS: begin
                  velocity[axis] = sdac_pkg::VEL_PLUS;
                  moving[axis]   = 1'b1;
                  target[axis]   = TOP_POSITION;
               end
               sdac_pkg::MODE_JOG_MINUS: begin
                  velocity[axis] = sdac_pkg::VEL_MINUS;
                  moving[axis]   = 1'b1;
                  target[axis]   = BOTTOM_POSITION;
               end
               sdac_pkg::MODE_MOVE: begin
                  target[axis] = position[axis] + amount;
                  if (amount == '0) begin
                     halt_axis(axis);
                  end else begin
                     velocity[axis] = amount[31] ? sdac_pkg::VEL_MINUS : sdac_pkg::VEL_PLUS;
                     moving[axis]   = 1'b1;
                  end
               end
               sdac_pkg::MODE_GOTO: begin
                  target[axis] = amount;
                  if ($signed(amount) == $signed(position[axis])) begin
                     halt_axis(axis);
                  end else begin
                     velocity[axis] = ($signed(amount) > $signed(position[axis])) ?
                                      sdac_pkg::VEL_PLUS : sdac_pkg::VEL_MINUS;
                     moving[axis]   = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end

         r = '0;
         r.status          = rejected;
         r.step_pulses     = pulses;
         r.step_directions = {direction[1], direction[0]};
         r.driver_enable_n = !(enabled[0] || enabled[1]);
         r.arrived         = arrivals;
         r.axis_position   = position[axis];
         r.axis_target     = target[axis];
         r.axis_moving     = moving[axis];
         r.axis_enabled    = enabled[axis];
         r.axis_homed      = homed[axis];
         r.axis_velocity   = velocity[axis];
         predicted_responses.push_back(r);
      endfunction

      function int axis_of(int a);
         return a;
      endfunction

      function void complain(string what);
         failures++;
         if (reported < 10) begin
            reported++;
            $display("error: %s", what);
         end
      endfunction

      function void compare_field(string field_name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            complain($sformatf("%s expected %h, got %h", field_name, want, got));
         end
      endfunction

      function void check_response(sdac_pkg::sdac_result_type got);
         sdac_pkg::sdac_result_type want;
         if (predicted_responses.size() == 0) begin
            complain($sformatf("response %h arrived with nothing outstanding", got));
            return;
         end
         want = predicted_responses.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("step_pulses", 32'(want.step_pulses), 32'(got.step_pulses));
         compare_field("step_directions", 32'(want.step_directions),
                       32'(got.step_directions));
         compare_field("driver_enable_n", 32'(want.driver_enable_n),
                       32'(got.driver_enable_n));
         compare_field("arrived", 32'(want.arrived), 32'(got.arrived));
         compare_field("axis_position", want.axis_position, got.axis_position);
         compare_field("axis_target", want.axis_target, got.axis_target);
         compare_field("axis_moving", 32'(want.axis_moving), 32'(got.axis_moving));
         compare_field("axis_enabled", 32'(want.axis_enabled), 32'(got.axis_enabled));
         compare_field("axis_homed", 32'(want.axis_homed), 32'(got.axis_homed));
         compare_field("axis_velocity", 32'(want.axis_velocity), 32'(got.axis_velocity));
         compare_field("pad", 32'(want.pad), 32'(got.pad));
      endfunction

      function void flag_leftovers();
         if (predicted_responses.size() != 0) begin
            complain($sformatf("%0d responses never arrived", predicted_responses.size()));
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [sdac_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [sdac_pkg::REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [sdac_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   int               sender_idle_pct   = 6;
   int               receiver_idle_pct = 75;
   motion_scoreboard board;

   step_dir_axis_controller #(
      .AXIS_COUNT    (AXES),
      .POSITION_BITS (32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs. It leaves a wide margin over the
   // length of a correct run.
   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

   // Offers one request transaction and returns once it has been accepted.
   // The sender may first idle at random. Values read straight after
   // the clock edge are those that held before it, as every driver here and
   // in the block updates through nonblocking assignments.
   task automatic send_request(input sdac_pkg::sdac_mode_type mode, input bit axis,
                               input logic [31:0] amount);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= amount;
      req_tuser  <= {3'b000, axis, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(mode, axis, amount);
   endtask

   // Ticks dominate so that the axes actually travel; enable on is common so
   // that most motion commands land on an enabled axis and get accepted.
   function automatic sdac_pkg::sdac_mode_type pick_mode();
      int roll;
      roll = $urandom_range(99);
      if (roll < 48)      return sdac_pkg::MODE_TICK;
      else if (roll < 56) return sdac_pkg::MODE_ENABLE_ON;
      else if (roll < 59) return sdac_pkg::MODE_ENABLE_OFF;
      else if (roll < 63) return sdac_pkg::MODE_HOME;
      else if (roll < 67) return sdac_pkg::MODE_STOP;
      else if (roll < 71) return sdac_pkg::MODE_JOG_PLUS;
      else if (roll < 75) return sdac_pkg::MODE_JOG_MINUS;
      else if (roll < 88) return sdac_pkg::MODE_MOVE;
      else                return sdac_pkg::MODE_GOTO;
   endfunction

   // Short moves and near gotos finish within a few ticks and so exercise
   // arrival; the occasional full-width value covers every amount bit and
   // sends an axis on a long run until something stops it.
   function automatic logic [31:0] pick_amount(sdac_pkg::sdac_mode_type mode);
      int roll;
      roll = $urandom_range(99);
      if (mode == sdac_pkg::MODE_MOVE || mode == sdac_pkg::MODE_GOTO) begin
         if (roll < 75)      return 32'($urandom_range(24)) - 32'd12;
         else if (roll < 88) return 32'($urandom_range(400)) - 32'd200;
         else if (roll < 92) return (roll[0]) ? TOP_POSITION : BOTTOM_POSITION;
         else                return $urandom;
      end
      return $urandom;
   endfunction

   task automatic run_random(input int count);
      sdac_pkg::sdac_mode_type mode;
      for (int i = 0; i < count; i++) begin
         mode = pick_mode();
         send_request(mode, 1'($urandom_range(1)), pick_amount(mode));
      end
   endtask

   // Receiver: stalls at the current rate, and checks every response
   // transaction taken while out of reset.
   initial begin
      forever begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            board.check_response(sdac_pkg::sdac_result_type'(rsp_tdata));
         end
      end
   end

   initial begin
      int waited;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender rarely idles, receiver stalls most of the time.
      sender_idle_pct   = 6;
      receiver_idle_pct = 75;

      // Directed part. Both axes start disabled, so motion commands are
      // refused while stop and home are still honoured.
      send_request(sdac_pkg::MODE_TICK, 1'b0, 32'h0000_0000);
      send_request(sdac_pkg::MODE_JOG_PLUS, 1'b0, 32'hFFFF_FFFF);
      send_request(sdac_pkg::MODE_MOVE, 1'b1, 32'd5);
      send_request(sdac_pkg::MODE_GOTO, 1'b0, TOP_POSITION);
      send_request(sdac_pkg::MODE_STOP, 1'b0, 32'h0000_0000);
      send_request(sdac_pkg::MODE_HOME, 1'b1, 32'hFFFF_FFFF);
      send_request(sdac_pkg::MODE_ENABLE_ON, 1'b0, 32'h0000_0000);
      send_request(sdac_pkg::MODE_ENABLE_ON, 1'b1, 32'h0000_0000);
      // A two-step move arrives on its second tick.
      send_request(sdac_pkg::MODE_MOVE, 1'b0, 32'd2);
      send_request(sdac_pkg::MODE_TICK, 1'b0, 32'h0000_0000);
      send_request(sdac_pkg::MODE_TICK, 1'b0, 32'hFFFF_FFFF);
      send_request(sdac_pkg::MODE_TICK, 1'b1, 32'h0000_0000);
      // A move of zero and a goto to the current position leave the axis idle.
      send_request(sdac_pkg::MODE_MOVE, 1'b1, 32'h0000_0000);
      send_request(sdac_pkg::MODE_GOTO, 1'b0, 32'd2);
      send_request(sdac_pkg::MODE_GOTO, 1'b1, 32'hFFFF_FFFD);
      send_request(sdac_pkg::MODE_JOG_MINUS, 1'b0, 32'h0000_0000);
      send_request(sdac_pkg::MODE_TICK, 1'b1, 32'h0000_0000);
      send_request(sdac_pkg::MODE_TICK, 1'b0, 32'h0000_0000);
      // Extremes of the amount, with relative moves that wrap round.
      send_request(sdac_pkg::MODE_GOTO, 1'b0, TOP_POSITION);
      send_request(sdac_pkg::MODE_GOTO, 1'b1, BOTTOM_POSITION);
      send_request(sdac_pkg::MODE_TICK, 1'b0, 32'h0000_0000);
      send_request(sdac_pkg::MODE_MOVE, 1'b0, BOTTOM_POSITION);
      send_request(sdac_pkg::MODE_MOVE, 1'b1, TOP_POSITION);
      send_request(sdac_pkg::MODE_TICK, 1'b1, 32'h0000_0000);
      // Disabling a moving axis stops it with the target pulled back.
      send_request(sdac_pkg::MODE_ENABLE_OFF, 1'b0, 32'h0000_0000);
      send_request(sdac_pkg::MODE_STOP, 1'b1, 32'h0000_0000);
      send_request(sdac_pkg::MODE_TICK, 1'b0, 32'h0000_0000);

      run_random(RANDOM_PER_PHASE);

      // Phase two: the other way round.
      sender_idle_pct   = 75;
      receiver_idle_pct = 6;
      run_random(RANDOM_PER_PHASE);

      // Phase three: full rate on both sides.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      run_random(RANDOM_PER_PHASE);
      req_tvalid <= 1'b0;

      // Drain, then allow for the pipeline in case anything stray follows.
      waited = 0;
      while (board.predicted_responses.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      board.flag_leftovers();

      if (board.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
